[hdl/fep_pkg.sv]
package fep_pkg;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_SPREAD = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_RESEED = 2'd3;

    localparam logic [7:0] PALETTE_TOP_RESET = 8'd36;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_FINISH
    } fep_state_t;

    typedef struct packed {
        logic accept;
        logic sweep_start;
        logic sweep_bottom;
        logic sweep_step;
        logic seed_en;
        logic exec_done;
        logic fin_done;
    } fep_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       sweep_last;
        logic       out_free;
    } fep_status_t;

endpackage

[hdl/fep_ctrl.sv]
module fep_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fep_pkg::fep_status_t stat,
    output fep_pkg::fep_cmd_t    cmd
);
    import fep_pkg::*;

    fep_state_t state_reg;
    fep_state_t state_next;
    logic       is_sweep_func;

    assign is_sweep_func = (stat.func == FUNC_CLEAR) || (stat.func == FUNC_RESEED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (is_sweep_func) begin
                    state_next = ST_SWEEP;
                end else if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (stat.sweep_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.sweep_step = 1'b1;
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_EXEC: begin
                if (is_sweep_func) begin
                    cmd.sweep_start  = 1'b1;
                    cmd.sweep_bottom = (stat.func == FUNC_RESEED);
                end else begin
                    cmd.exec_done = stat.out_free;
                end
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                cmd.seed_en    = 1'b1;
            end
            ST_FINISH: begin
                cmd.fin_done = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hdl/fep_datapath.sv]
module fep_datapath #(
    parameter int FIRE_WIDTH  = 64,
    parameter int FIRE_HEIGHT = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fep_pkg::fep_cmd_t    cmd,
    output fep_pkg::fep_status_t stat,
    input  logic                 cfg_write,
    input  logic [7:0]           cfg_palette_top,
    input  logic [1:0]           s_func,
    input  logic [5:0]           s_col,
    input  logic [6:0]           s_row,
    input  logic [1:0]           s_shift,
    input  logic                 s_decay,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_pixel,
    output logic                 m_ok
);
    import fep_pkg::*;

    localparam int DEPTH = FIRE_WIDTH * FIRE_HEIGHT;
    localparam int CW    = $clog2(FIRE_WIDTH);
    localparam int RW    = $clog2(FIRE_HEIGHT);
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = CW + 2;
    localparam int BASE  = (FIRE_HEIGHT - 1) * FIRE_WIDTH;

    logic [7:0] mem [DEPTH];

    logic [7:0]    palette_top_reg;
    logic [1:0]    func_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [1:0]    shift_reg;
    logic          decay_reg;
    logic          ok_reg;
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] sweep_cnt_reg;
    logic          m_valid_reg;
    logic [7:0]    m_pixel_reg;
    logic          m_ok_reg;

    logic          in_range;
    logic [AW-1:0] src_addr;
    logic [TW-1:0] drift_sum;
    logic [CW-1:0] dest_col;
    logic [AW-1:0] dest_addr;
    logic [7:0]    spread_val;
    logic [7:0]    exec_pixel;
    logic [7:0]    sweep_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          out_free;

    assign in_range = (32'(s_col) < 32'(FIRE_WIDTH)) && (32'(s_row) < 32'(FIRE_HEIGHT));
    assign src_addr = AW'(AW'(RW'(s_row)) * AW'(FIRE_WIDTH) + AW'(CW'(s_col)));

    assign drift_sum = TW'(col_reg) + TW'(FIRE_WIDTH + 1) - TW'(shift_reg);

    always_comb begin
        if (drift_sum >= TW'(2 * FIRE_WIDTH)) begin
            dest_col = CW'(drift_sum - TW'(2 * FIRE_WIDTH));
        end else if (drift_sum >= TW'(FIRE_WIDTH)) begin
            dest_col = CW'(drift_sum - TW'(FIRE_WIDTH));
        end else begin
            dest_col = CW'(drift_sum);
        end
    end

    assign spread_val = (rd_data_reg == 8'd0) ? 8'd0 : rd_data_reg - 8'(decay_reg);

    always_comb begin
        if (rd_data_reg == 8'd0) begin
            dest_addr = AW'(AW'(row_reg - RW'(1)) * AW'(FIRE_WIDTH) + AW'(col_reg));
        end else begin
            dest_addr = AW'(AW'(row_reg - RW'(1)) * AW'(FIRE_WIDTH) + AW'(dest_col));
        end
    end

    always_comb begin
        exec_pixel = 8'd0;
        if (ok_reg) begin
            if (func_reg == FUNC_READ) begin
                exec_pixel = rd_data_reg;
            end else begin
                exec_pixel = spread_val;
            end
        end
    end

    assign sweep_data = (cmd.seed_en && (sweep_cnt_reg >= AW'(BASE))) ? palette_top_reg : 8'd0;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = sweep_cnt_reg;
        mem_wdata = sweep_data;
        if (cmd.sweep_step) begin
            mem_we = 1'b1;
        end else if (cmd.exec_done && ok_reg && (func_reg == FUNC_SPREAD)) begin
            mem_we    = 1'b1;
            mem_waddr = dest_addr;
            mem_wdata = spread_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept) begin
            rd_data_reg <= mem[src_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg  <= s_func;
            col_reg   <= CW'(s_col);
            row_reg   <= RW'(s_row);
            shift_reg <= s_shift;
            decay_reg <= s_decay;
            ok_reg    <= in_range && ((s_func != FUNC_SPREAD) || (s_row != 7'd0));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_top_reg <= PALETTE_TOP_RESET;
        end else if (cfg_write) begin
            palette_top_reg <= cfg_palette_top;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
        end else if (cmd.sweep_start) begin
            sweep_cnt_reg <= cmd.sweep_bottom ? AW'(BASE) : '0;
        end else if (cmd.sweep_step) begin
            sweep_cnt_reg <= sweep_cnt_reg + AW'(1);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec_done || cmd.fin_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec_done) begin
            m_pixel_reg <= exec_pixel;
            m_ok_reg    <= ok_reg;
        end else if (cmd.fin_done) begin
            m_pixel_reg <= 8'd0;
            m_ok_reg    <= 1'b1;
        end
    end

    assign stat.func       = func_reg;
    assign stat.sweep_last = (sweep_cnt_reg == AW'(DEPTH - 1));
    assign stat.out_free   = out_free;

    assign m_valid = m_valid_reg;
    assign m_pixel = m_pixel_reg;
    assign m_ok    = m_ok_reg;

endmodule

[hdl/fire_effect_propagator.sv]
// A spread or read request reads its source pixel when it is accepted; the execute state then writes
// the spread pixel and registers the result once the output is free, and s_ready stays low until then.
// Clear sweeps the whole frame memory, one write per cycle, zeroing every row but the bottom one,
// which gets the palette top value; reseed sweeps only the bottom row, writing that value into it.
// Either result is registered once the sweep has ended and the output is free.
// After reset a clearing pass zeros the whole memory with s_ready low; the palette register
// resets to 36 and configuration writes are taken at once.
module fire_effect_propagator #(
    parameter int FIRE_WIDTH  = 64,
    parameter int FIRE_HEIGHT = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_palette_top,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [5:0] s_col,
    input  logic [6:0] s_row,
    input  logic [1:0] s_shift,
    input  logic       s_decay,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_pixel,
    output logic       m_ok
);
    import fep_pkg::*;

    fep_cmd_t    cmd;
    fep_status_t stat;

    assign cfg_ready = 1'b1;

    fep_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fep_datapath #(
        .FIRE_WIDTH  (FIRE_WIDTH),
        .FIRE_HEIGHT (FIRE_HEIGHT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_palette_top (cfg_palette_top),
        .s_func          (s_func),
        .s_col           (s_col),
        .s_row           (s_row),
        .s_shift         (s_shift),
        .s_decay         (s_decay),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel         (m_pixel),
        .m_ok            (m_ok)
    );

endmodule
